// ===== design/bal_pkg.sv =====
// Types, constants and state codes for the buddy allocator.
package bal_pkg;
    localparam int POOL_UNITS  = 1024;
    localparam int MAX_ENTRIES = 1024;
    localparam int OWNER_BITS  = 8;
    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W  = $clog2(POOL_UNITS);
    localparam int TOP_ORD = $clog2(POOL_UNITS + 1) - 1;
    localparam int ORD_W   = $clog2(TOP_ORD + 2);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_NOOWNER = 2'd2;
    localparam logic       OP_ALLOC   = 1'b0;
    localparam logic       OP_FREE    = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [10:0] request_size;
        logic [7:0]  owner_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  block_start;
        logic [10:0] block_size;
        logic [9:0]  waste;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]     start;
        logic [ORD_W-1:0]      order;
        logic                  used;
        logic [OWNER_BITS-1:0] owner;
    } entry_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_SCANW, S_SHIFT, S_SHIFTW, S_SPLIT,
        S_FSCAN, S_MSCAN, S_MCHK, S_MSHIFT, S_MSHIFTW, S_DONE
    } state_t;
endpackage

// ===== design/buddy_allocator.sv =====
// Buddy allocator top level: sequencer around the block table memory.
// Allocate: accept, one pass over the table, then per split a shift of the tail
// (one moved entry at a time) plus the split and write-back steps, then done.
// Free: scan to the owner, then merge passes, each a table scan plus a
// tail shift; one word at a time.
// Result waits in an output register; reset clears control, then S_INIT writes entry 0.
module buddy_allocator
    import bal_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output rsp_t out_data
);
    state_t state_reg, state_next;
    req_t   req_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W:0]   idx_reg, idx_next;      // scan / shift pointer
    logic [IDX_W-1:0] best_reg, best_next;
    logic             found_reg, found_next;
    logic [ORD_W-1:0] bord_reg, bord_next;
    logic [ORD_W-1:0] word_reg;               // wanted order
    logic [11:0]      eff_reg;
    entry_t           prev_reg, prev_next;    // previous entry in merge scan
    rsp_t             rsp_reg, rsp_next;
    rsp_t             out_reg, out_next;
    logic             ov_reg, ov_next;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    entry_t           wdata, rdata;

    bal_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                   .raddr(raddr), .rdata(rdata));

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    // request order from size
    logic [11:0]      eff_c;
    logic [ORD_W-1:0] ord_c;
    always_comb
    begin
        eff_c = (in_data.request_size == 11'd0) ? 12'd1 : {1'b0, in_data.request_size};
        ord_c = '0;
        for (int k = 11; k >= 0; k--)
        begin
            if (eff_c > (12'd1 << k))
            begin
                if (ord_c == '0)
                begin
                    ord_c = ORD_W'(k + 1);
                end
            end
        end
    end

    logic [IDX_W-1:0] ix;
    logic [11:0]      sz_prev;
    assign ix = idx_reg[IDX_W-1:0];
    assign sz_prev = 12'd1 << prev_reg.order;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg; idx_next = idx_reg; best_next = best_reg;
        found_next = found_reg; bord_next = bord_reg; prev_next = prev_reg;
        rsp_next = rsp_reg;
        out_next = out_reg;
        ov_next = ov_reg && out_stall;
        we = 1'b0; waddr = ix; wdata = rdata; raddr = ix;
        case (state_reg)
            S_INIT:
            begin
                we = 1'b1; waddr = '0;
                wdata = '{start: '0, order: ORD_W'(TOP_ORD), used: 1'b0, owner: '0};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = '0; found_next = 1'b0; raddr = '0;
                    rsp_next = '0;
                    if (in_data.opcode == OP_ALLOC)
                    begin
                        if (ord_c > ORD_W'(TOP_ORD))
                        begin
                            rsp_next.status = ST_NOSPACE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = S_FSCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // rdata holds entry idx_reg
                if (!rdata.used && rdata.order >= word_reg &&
                    (!found_reg || rdata.order < bord_reg))
                begin
                    found_next = 1'b1; best_next = ix; bord_next = rdata.order;
                end
                idx_next = idx_reg + 1'b1;
                raddr = idx_next[IDX_W-1:0];
                if (idx_next == (IDX_W+1)'(cnt_reg))
                begin
                    state_next = S_SCANW;
                end
            end
            S_SCANW:
            begin
                if (!found_next || (CNT_W+1)'(cnt_reg) + (CNT_W+1)'(bord_reg - word_reg)
                    > (CNT_W+1)'(MAX_ENTRIES))
                begin
                    state_next = S_DONE;
                    rsp_next.status = ST_NOSPACE;
                end
                else
                begin
                    idx_next = (IDX_W+1)'(cnt_reg) - 1'b1;
                    raddr = idx_next[IDX_W-1:0];
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // move tail one slot up, from the top down to best+1
                if (idx_reg[IDX_W-1:0] == best_reg || bord_reg == word_reg)
                begin
                    raddr = best_reg;
                    state_next = S_SPLIT;
                end
                else
                begin
                    we = 1'b1; waddr = IDX_W'(idx_reg + 1'b1); wdata = rdata;
                    idx_next = idx_reg - 1'b1;
                    raddr = idx_next[IDX_W-1:0];
                    state_next = S_SHIFTW;
                end
            end
            S_SHIFTW:
            begin
                raddr = ix;
                state_next = S_SHIFT;
            end
            S_SPLIT:
            begin
                // rdata is the best entry
                if (bord_reg == word_reg)
                begin
                    we = 1'b1; waddr = best_reg;
                    wdata = rdata; wdata.used = 1'b1;
                    wdata.owner = req_reg.owner_id[OWNER_BITS-1:0];
                    rsp_next.status = ST_OK;
                    rsp_next.block_start = 10'(rdata.start);
                    rsp_next.block_size = 11'(12'd1 << word_reg);
                    rsp_next.waste = 10'((12'd1 << word_reg) - eff_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    we = 1'b1; waddr = best_reg + 1'b1;
                    wdata.start = rdata.start + ADDR_W'(12'd1 << (bord_reg - 1'b1));
                    wdata.order = bord_reg - 1'b1;
                    wdata.used = 1'b0; wdata.owner = '0;
                    prev_next = rdata; prev_next.order = bord_reg - 1'b1;
                    bord_next = bord_reg - 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    state_next = S_MSHIFTW; // write back lowered best, then reshift
                end
            end
            S_MSHIFTW:
            begin
                if (found_reg)
                begin
                    we = 1'b1; waddr = best_reg; wdata = prev_reg;
                    idx_next = (IDX_W+1)'(cnt_reg) - 1'b1;
                    raddr = idx_next[IDX_W-1:0];
                    state_next = S_SHIFT;
                end
                else
                begin
                    // merge: restart scan from the beginning
                    idx_next = '0; raddr = '0;
                    state_next = S_MSCAN;
                end
            end
            S_FSCAN:
            begin
                if (rdata.used && rdata.owner == req_reg.owner_id[OWNER_BITS-1:0])
                begin
                    we = 1'b1; waddr = ix; wdata.used = 1'b0; wdata.owner = '0;
                    rsp_next.block_start = 10'(rdata.start);
                    rsp_next.block_size = 11'(12'd1 << rdata.order);
                    idx_next = '0; raddr = '0;
                    state_next = S_MSCAN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    raddr = idx_next[IDX_W-1:0];
                    if (idx_next == (IDX_W+1)'(cnt_reg))
                    begin
                        rsp_next.status = ST_NOOWNER;
                        state_next = S_DONE;
                    end
                end
            end
            S_MSCAN:
            begin
                // idle state so the read sees the last write
                raddr = '0;
                idx_next = '0;
                state_next = S_MCHK;
            end
            S_MCHK:
            begin
                if (idx_reg != '0 && !prev_reg.used && !rdata.used &&
                    prev_reg.order == rdata.order &&
                    (12'(prev_reg.start) + sz_prev) == 12'(rdata.start) &&
                    ((12'(prev_reg.start) & ((sz_prev << 1) - 12'd1)) == 12'd0))
                begin
                    we = 1'b1; waddr = IDX_W'(idx_reg - 1'b1);
                    wdata = prev_reg; wdata.order = prev_reg.order + 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    idx_next = idx_reg + 1'b1;
                    raddr = idx_next[IDX_W-1:0];
                    state_next = S_MSHIFT;
                end
                else
                begin
                    prev_next = rdata;
                    idx_next = idx_reg + 1'b1;
                    raddr = idx_next[IDX_W-1:0];
                    if (idx_next == (IDX_W+1)'(cnt_reg))
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MSHIFT:
            begin
                // move entries down one slot after a merge
                if (idx_reg > (IDX_W+1)'(cnt_reg))
                begin
                    idx_next = '0; raddr = '0;
                    state_next = S_MSCAN;
                end
                else
                begin
                    we = 1'b1; waddr = IDX_W'(idx_reg - 1'b1); wdata = rdata;
                    idx_next = idx_reg + 1'b1;
                    raddr = idx_next[IDX_W-1:0];
                end
            end
            S_DONE:
            begin
                // hold until the previous result word has left
                if (!ov_reg || !out_stall)
                begin
                    out_next = rsp_reg;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= CNT_W'(1);
            ov_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            found_reg <= (state_reg == S_FSCAN || state_reg == S_MCHK) ? 1'b0 : found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        best_reg <= best_next;
        bord_reg <= bord_next;
        prev_reg <= prev_next;
        rsp_reg  <= rsp_next;
        out_reg  <= out_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            req_reg  <= in_data;
            word_reg <= ord_c;
            eff_reg  <= eff_c;
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg != S_IDLE)
        else $error("item accepted without leaving idle");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 && cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("block count out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result word dropped");
endmodule

// ===== design/bal_ram.sv =====
// Block table memory: one write port, one registered read port.
module bal_ram
    import bal_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  entry_t            wdata,
    input  logic [IDX_W-1:0]  raddr,
    output entry_t            rdata
);
    entry_t mem [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== tb/buddy_allocator_tb.sv =====
// Testbench for the buddy allocator: directed and random words checked against a local model.
`timescale 1ns / 100ps

module buddy_allocator_tb
    import bal_pkg::*;
();

    localparam int CYCLE_LIMIT = 20000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    req_t in_data;
    logic out_valid;
    logic out_stall;
    rsp_t out_data;

    buddy_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // local copy of the block table
    int blk_start [MAX_ENTRIES];
    int blk_order [MAX_ENTRIES];
    bit blk_used  [MAX_ENTRIES];
    int blk_owner [MAX_ENTRIES];
    int blk_count;

    rsp_t expected_rsp_q[$];
    int   error_count;
    int   mismatch_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   recv_hold;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic rsp_t predict_block(req_t w);
        rsp_t r;
        int   eff;
        int   ord;
        int   best;
        int   b;
        int   i;
        int   j;
        int   sz;
        bit   found;
        bit   merged;
        r = '0;
        if (w.opcode == OP_ALLOC)
        begin
            eff = (w.request_size == 0) ? 1 : int'(w.request_size);
            ord = 0;
            while ((1 << ord) < eff)
                ord++;
            best = -1;
            if (ord <= TOP_ORD)
            begin
                for (i = 0; i < blk_count; i++)
                    if (!blk_used[i] && blk_order[i] >= ord &&
                        (best < 0 || blk_order[i] < blk_order[best]))
                        best = i;
            end
            if (best >= 0 && blk_count + blk_order[best] - ord <= MAX_ENTRIES)
            begin
                b = best;
                while (blk_order[b] > ord)
                begin
                    for (i = blk_count; i > b + 1; i--)
                    begin
                        blk_start[i] = blk_start[i-1];
                        blk_order[i] = blk_order[i-1];
                        blk_used[i]  = blk_used[i-1];
                        blk_owner[i] = blk_owner[i-1];
                    end
                    blk_order[b]--;
                    blk_start[b+1] = blk_start[b] + (1 << blk_order[b]);
                    blk_order[b+1] = blk_order[b];
                    blk_used[b+1]  = 1'b0;
                    blk_owner[b+1] = 0;
                    blk_count++;
                end
                blk_used[b]   = 1'b1;
                blk_owner[b]  = int'(w.owner_id);
                r.block_start = 10'(blk_start[b]);
                r.block_size  = 11'(1 << ord);
                r.waste       = 10'((1 << ord) - eff);
            end
            else
                r.status = ST_NOSPACE;
        end
        else
        begin
            found = 1'b0;
            for (i = 0; i < blk_count && !found; i++)
            begin
                if (blk_used[i] && blk_owner[i] == int'(w.owner_id))
                begin
                    blk_used[i]   = 1'b0;
                    blk_owner[i]  = 0;
                    r.block_start = 10'(blk_start[i]);
                    r.block_size  = 11'(1 << blk_order[i]);
                    found = 1'b1;
                end
            end
            if (!found)
                r.status = ST_NOOWNER;
            else
            begin
                // only aligned buddies merge
                do
                begin
                    merged = 1'b0;
                    for (i = 0; i + 1 < blk_count && !merged; i++)
                    begin
                        sz = 1 << blk_order[i];
                        if (!blk_used[i] && !blk_used[i+1] && blk_order[i] == blk_order[i+1] &&
                            blk_start[i] + sz == blk_start[i+1] &&
                            (blk_start[i] % (2 * sz)) == 0)
                        begin
                            blk_order[i]++;
                            for (j = i + 1; j < blk_count - 1; j++)
                            begin
                                blk_start[j] = blk_start[j+1];
                                blk_order[j] = blk_order[j+1];
                                blk_used[j]  = blk_used[j+1];
                                blk_owner[j] = blk_owner[j+1];
                            end
                            blk_count--;
                            merged = 1'b1;
                        end
                    end
                end
                while (merged);
            end
        end
        return r;
    endfunction

    // one word offered with random idle gaps; returns just after the accepting edge
    task automatic send_word(logic op, int size, int owner);
        req_t w;
        w.opcode       = op;
        w.request_size = size[10:0];
        w.owner_id     = owner[7:0];
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = w;
        do
            @(posedge clk);
        while (in_stall);
        expected_rsp_q.push_back(predict_block(w));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // owner of a random live block, or a random tag now and then
    function automatic int pick_owner();
        int live[$];
        for (int i = 0; i < blk_count; i++)
            if (blk_used[i])
                live.push_back(blk_owner[i]);
        if (live.size() == 0 || $urandom_range(99) < 15)
            return $urandom_range(255);
        return live[$urandom_range(live.size() - 1)];
    endfunction

    task automatic send_random_word();
        int r;
        int size;
        r = $urandom_range(99);
        if (r < 70)
            size = $urandom_range(40);
        else if (r < 90)
            size = $urandom_range(300);
        else
            size = $urandom_range(2047);
        if ($urandom_range(99) < 40)
            send_word(OP_FREE, $urandom_range(2047), pick_owner());
        else
            send_word(OP_ALLOC, size, $urandom_range(255));
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(OP_ALLOC, 0, 0);       // zero counts as one unit
        send_word(OP_FREE, 0, 0);
        send_word(OP_ALLOC, 1024, 255);  // whole pool
        send_word(OP_ALLOC, 1, 1);       // no space left
        send_word(OP_FREE, 2047, 255);
        send_word(OP_ALLOC, 2047, 3);    // too large
        send_word(OP_ALLOC, 1025, 3);
        send_word(OP_FREE, 0, 77);       // owner not found
        send_word(OP_ALLOC, 3, 5);
        send_word(OP_ALLOC, 513, 6);     // no fitting block
        send_word(OP_ALLOC, 512, 6);
        send_word(OP_ALLOC, 5, 5);       // second block, same owner
        send_word(OP_FREE, 0, 5);        // lowest address first
        send_word(OP_FREE, 0, 5);
        send_word(OP_FREE, 0, 6);
        send_word(OP_ALLOC, 256, 8);
        send_word(OP_ALLOC, 256, 9);
        send_word(OP_ALLOC, 1, 128);
        send_word(OP_FREE, 0, 8);
        send_word(OP_FREE, 0, 9);
        send_word(OP_FREE, 0, 128);
        send_word(OP_ALLOC, 1024, 10);
        send_word(OP_FREE, 0, 10);
        wait_drained();
    endtask

    task automatic test_random(int idle_pct, int stall_pct, int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n)
            send_random_word();
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (400)
                    @(posedge clk);
                recv_hold = 1'b0;
            end
            repeat (10)
                send_random_word();
        join
        wait_drained();
        repeat (30)
            @(posedge clk);
        test_random(0, 0, 6);
    endtask

    always @(negedge clk)
        out_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                error_count++;
                if (mismatch_count++ < 10)
                    $display("unexpected result word %h", out_data);
            end
            else
            begin
                e = expected_rsp_q.pop_front();
                if (out_data.status !== e.status || out_data.block_start !== e.block_start ||
                    out_data.block_size !== e.block_size || out_data.waste !== e.waste)
                begin
                    error_count++;
                    if (mismatch_count++ < 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 e.status, e.block_start, e.block_size, e.waste,
                                 out_data.status, out_data.block_start,
                                 out_data.block_size, out_data.waste);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        recv_hold      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        blk_start[0]   = 0;
        blk_order[0]   = TOP_ORD;
        blk_used[0]    = 1'b0;
        blk_owner[0]   = 0;
        blk_count      = 1;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(0, 0, 25);
        test_random(70, 0, 25);
        test_random(0, 70, 25);
        test_random(31, 31, 25);
        test_backpressure();

        repeat (100)
            @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== buddy_allocator.f =====
design/bal_pkg.sv
design/bal_ram.sv
design/buddy_allocator.sv
tb/buddy_allocator_tb.sv
